FILE: hdl/ssm_pkg.sv
package ssm_pkg;

    // Default configuration
    localparam int DEPTH_DEF      = 1024;
    localparam int BLOCK_SIZE_DEF = 32;
    localparam int NUM_BLOCKS_DEF = 32;

    // Fixed field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 48;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Microprogram counter
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Sequencing of one control word
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_BR,
        SEQ_LOOP,
        SEQ_FETCH,
        SEQ_EMIT,
        SEQ_END
    } seq_op_t;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_CLR_END,
        C_WBAD,
        C_BASE_GT,
        C_SCAN_END,
        C_LT,
        C_SUMEQ,
        C_EEND,
        C_EHIT
    } cond_t;

    typedef enum logic [1:0] {SRD_NONE, SRD_PTR, SRD_NEXT} srd_t;
    typedef enum logic [1:0] {PTR_HOLD, PTR_INC, PTR_DEC} ptr_op_t;
    typedef enum logic [1:0] {ERD_NONE, ERD_IDX, ERD_POS} erd_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

    // Datapath operations of one step
    typedef struct packed {
        srd_t    sum_rd;
        logic    sum_wr;
        ptr_op_t ptr_op;
        erd_t    elem_rd;
        logic    elem_wr;
        acc_op_t acc_op;
        logic    latch_blk;
        logic    clr;
    } dp_ops_t;

    typedef struct packed {
        seq_op_t seq;
        cond_t   cond;
        upc_t    jaddr;
        logic    emit_val;
        dp_ops_t ops;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic    load;
        logic    load_kind;
        dp_ops_t ops;
    } dp_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic clr_end;
        logic wbad;
        logic base_gt;
        logic scan_end;
        logic sum_lt;
        logic sum_eq;
        logic elem_end;
        logic elem_hit;
    } dp_flags_t;

    localparam dp_ops_t OPS_NONE = '{
        sum_rd:    SRD_NONE,
        sum_wr:    1'b0,
        ptr_op:    PTR_HOLD,
        elem_rd:   ERD_NONE,
        elem_wr:   1'b0,
        acc_op:    ACC_HOLD,
        latch_blk: 1'b0,
        clr:       1'b0
    };

    // Program addresses
    localparam upc_t A_CLR   = 5'd0;
    localparam upc_t A_FETCH = 5'd1;
    localparam upc_t A_W0    = 5'd2;
    localparam upc_t A_W1    = 5'd3;
    localparam upc_t A_W2    = 5'd4;
    localparam upc_t A_W3    = 5'd5;
    localparam upc_t A_END   = 5'd6;
    localparam upc_t A_Q0    = 5'd7;
    localparam upc_t A_Q1    = 5'd8;
    localparam upc_t A_Q2    = 5'd9;
    localparam upc_t A_Q3    = 5'd10;
    localparam upc_t A_Q4    = 5'd11;
    localparam upc_t A_Q5    = 5'd12;
    localparam upc_t A_Q6    = 5'd13;
    localparam upc_t A_Q7    = 5'd14;
    localparam upc_t A_NO    = 5'd15;
    localparam upc_t A_YES   = 5'd16;
    localparam upc_t A_LAST  = A_YES;

    // Control store. A LOOP word stays put and runs its operations until its
    // condition holds, then jumps without running them.
    function automatic ucode_t ucode_rom(upc_t addr);
        ucode_t w;
        w = '{seq: SEQ_END, cond: C_NONE, jaddr: A_FETCH, emit_val: 1'b0, ops: OPS_NONE};
        case (addr)
            // clear both memories after reset
            A_CLR:
            begin
                w.seq = SEQ_LOOP; w.cond = C_CLR_END; w.jaddr = A_FETCH;
                w.ops.clr = 1'b1;
            end
            A_FETCH:
            begin
                w.seq = SEQ_FETCH;
            end
            // write: read old element
            A_W0:
            begin
                w.seq = SEQ_BR; w.cond = C_WBAD; w.jaddr = A_END;
                w.ops.elem_rd = ERD_IDX;
            end
            // store element, form delta, read sum of block 0
            A_W1:
            begin
                w.seq = SEQ_NEXT;
                w.ops.elem_wr = 1'b1;
                w.ops.sum_rd  = SRD_PTR;
                w.ops.ptr_op  = PTR_INC;
            end
            // update block sums up to the written block
            A_W2:
            begin
                w.seq = SEQ_LOOP; w.cond = C_BASE_GT; w.jaddr = A_W3;
                w.ops.sum_wr = 1'b1;
                w.ops.sum_rd = SRD_PTR;
                w.ops.ptr_op = PTR_INC;
            end
            A_W3:
            begin
                w.seq = SEQ_END;
                w.ops.sum_wr = 1'b1;
            end
            A_END:
            begin
                w.seq = SEQ_END;
            end
            // query: scan block sums from the last block down
            A_Q0:
            begin
                w.seq = SEQ_NEXT;
                w.ops.sum_rd = SRD_PTR;
                w.ops.ptr_op = PTR_DEC;
            end
            A_Q1:
            begin
                w.seq = SEQ_LOOP; w.cond = C_SCAN_END; w.jaddr = A_Q2;
                w.ops.sum_rd = SRD_PTR;
                w.ops.ptr_op = PTR_DEC;
            end
            A_Q2:
            begin
                w.seq = SEQ_BR; w.cond = C_LT; w.jaddr = A_NO;
            end
            A_Q3:
            begin
                w.seq = SEQ_BR; w.cond = C_SUMEQ; w.jaddr = A_YES;
                w.ops.sum_rd    = SRD_NEXT;
                w.ops.latch_blk = 1'b1;
            end
            A_Q4:
            begin
                w.seq = SEQ_NEXT;
                w.ops.acc_op = ACC_LOAD;
            end
            A_Q5:
            begin
                w.seq = SEQ_NEXT;
                w.ops.elem_rd = ERD_POS;
            end
            // walk the found block backwards
            A_Q6:
            begin
                w.seq = SEQ_LOOP; w.cond = C_EEND; w.jaddr = A_Q7;
                w.ops.acc_op  = ACC_ADD;
                w.ops.elem_rd = ERD_POS;
            end
            A_Q7:
            begin
                w.seq = SEQ_BR; w.cond = C_EHIT; w.jaddr = A_YES;
            end
            A_NO:
            begin
                w.seq = SEQ_EMIT; w.emit_val = 1'b0;
            end
            A_YES:
            begin
                w.seq = SEQ_EMIT; w.emit_val = 1'b1;
            end
            default:
            begin
                w.seq = SEQ_END;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/ssm_cmd_if.sv
interface ssm_cmd_if
    import ssm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [SUM_W-1:0] target;

    modport source (output valid, kind, index, value, target, input ready);
    modport sink   (input valid, kind, index, value, target, output ready);
endinterface

FILE: hdl/ssm_rsp_if.sv
interface ssm_rsp_if
    import ssm_pkg::*;
();
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

FILE: hdl/ssm_dp.sv
module ssm_dp
    import ssm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_ctrl_t         ctrl,
    input  logic [IDX_W-1:0] index,
    input  logic [VAL_W-1:0] value,
    input  logic [SUM_W-1:0] target,
    output dp_flags_t        flags
);

    localparam int SLOT_COUNT = NUM_BLOCKS * BLOCK_SIZE;
    localparam int MEM_DEPTH  = (DEPTH < SLOT_COUNT) ? DEPTH : SLOT_COUNT;
    localparam int EA_W       = $clog2(MEM_DEPTH);
    localparam int BW         = $clog2(NUM_BLOCKS);
    localparam int PTR_W      = BW + 1;
    localparam int KW         = $clog2(BLOCK_SIZE);
    localparam int POS_RAW    = $clog2(SLOT_COUNT + BLOCK_SIZE) + 1;
    localparam int POS_W      = (POS_RAW > IDX_W) ? POS_RAW : IDX_W;
    localparam int CLR_N      = (MEM_DEPTH > NUM_BLOCKS) ? MEM_DEPTH : NUM_BLOCKS;
    localparam int CW         = $clog2(CLR_N + 1);

    localparam logic [POS_W-1:0] BS_P     = POS_W'(BLOCK_SIZE);
    localparam logic [POS_W-1:0] TOP_BASE = POS_W'((NUM_BLOCKS - 1) * BLOCK_SIZE);
    localparam logic [POS_W-1:0] LIMIT_P  = POS_W'(MEM_DEPTH);
    localparam logic [PTR_W-1:0] TOP_PTR  = PTR_W'(NUM_BLOCKS - 1);
    localparam logic [BW-1:0]    LAST_BLK = BW'(NUM_BLOCKS - 1);
    localparam logic [KW-1:0]    K_TOP    = KW'(BLOCK_SIZE - 1);
    localparam logic [CW-1:0]    CLR_C    = CW'(CLR_N);
    localparam logic [CW-1:0]    CLR_ELEM = CW'(MEM_DEPTH);
    localparam logic [CW-1:0]    CLR_SUM  = CW'(NUM_BLOCKS);

    // Storage
    logic [VAL_W-1:0] elem_mem [MEM_DEPTH];
    logic [SUM_W-1:0] sum_mem  [NUM_BLOCKS];

    // Item registers
    logic [POS_W-1:0] idx_reg;
    logic [VAL_W-1:0] val_reg;
    logic [SUM_W-1:0] tgt_reg;
    logic [SUM_W-1:0] delta_reg;

    // Block walk
    logic [PTR_W-1:0] ptr_reg;
    logic [POS_W-1:0] base_reg;
    logic [BW-1:0]    rd_blk_reg;
    logic [POS_W-1:0] rd_base_reg;
    logic [SUM_W-1:0] sum_rd_reg;
    logic [BW-1:0]    fblk_reg;
    logic [POS_W-1:0] fbase_reg;

    // Element walk
    logic [POS_W-1:0] epos_reg;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    rd_k_reg;
    logic [VAL_W-1:0] elem_rd_reg;
    logic             elem_zero_reg;
    logic [SUM_W-1:0] acc_reg;

    logic [CW-1:0]    clr_reg;
    logic [CW-1:0]    clr_next;

    logic [BW-1:0]    sa;
    logic [POS_W-1:0] sa_base;
    logic [POS_W-1:0] ea_pos;
    logic [EA_W-1:0]  ea;
    logic             ea_zero;
    logic [SUM_W-1:0] elem_val;
    logic [SUM_W-1:0] acc_sum;
    logic [SUM_W-1:0] sum_upd;
    logic             sum_ge;

    // Read addresses
    always_comb
    begin
        case (ctrl.ops.sum_rd)
            SRD_PTR:
            begin
                sa      = ptr_reg[BW-1:0];
                sa_base = base_reg;
            end
            SRD_NEXT:
            begin
                sa      = (rd_blk_reg == LAST_BLK) ? rd_blk_reg : rd_blk_reg + BW'(1);
                sa_base = rd_base_reg + BS_P;
            end
            default:
            begin
                sa      = rd_blk_reg;
                sa_base = rd_base_reg;
            end
        endcase
    end

    assign ea_pos  = (ctrl.ops.elem_rd == ERD_IDX) ? idx_reg : epos_reg;
    assign ea      = ea_pos[EA_W-1:0];
    assign ea_zero = (ea_pos >= LIMIT_P);

    // Arithmetic
    assign elem_val = elem_zero_reg ? '0 : SUM_W'(elem_rd_reg);
    assign acc_sum  = acc_reg + elem_val;
    assign sum_upd  = sum_rd_reg + delta_reg;
    assign sum_ge   = (sum_rd_reg >= tgt_reg);

    // Status to sequencer
    always_comb
    begin
        flags.clr_end  = (clr_reg == CLR_C);
        flags.wbad     = (idx_reg >= LIMIT_P);
        flags.base_gt  = (base_reg > idx_reg);
        flags.scan_end = sum_ge || (rd_blk_reg == '0);
        flags.sum_lt   = !sum_ge;
        flags.sum_eq   = (sum_rd_reg == tgt_reg);
        flags.elem_hit = (acc_sum == tgt_reg);
        flags.elem_end = (acc_sum == tgt_reg) || (rd_k_reg == '0);
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.ops.clr && (clr_reg < CLR_ELEM))
        begin
            elem_mem[clr_reg[EA_W-1:0]] <= '0;
        end
        else if (ctrl.ops.elem_wr)
        begin
            elem_mem[idx_reg[EA_W-1:0]] <= val_reg;
        end
        if (ctrl.ops.elem_rd != ERD_NONE)
        begin
            elem_rd_reg   <= elem_mem[ea];
            elem_zero_reg <= ea_zero;
        end
    end

    // Block sum memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.ops.clr && (clr_reg < CLR_SUM))
        begin
            sum_mem[clr_reg[BW-1:0]] <= '0;
        end
        else if (ctrl.ops.sum_wr)
        begin
            sum_mem[rd_blk_reg] <= sum_upd;
        end
        if (ctrl.ops.sum_rd != SRD_NONE)
        begin
            sum_rd_reg  <= sum_mem[sa];
            rd_blk_reg  <= sa;
            rd_base_reg <= sa_base;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            idx_reg  <= POS_W'(index);
            val_reg  <= value;
            tgt_reg  <= target;
            ptr_reg  <= (ctrl.load_kind == KIND_QUERY) ? TOP_PTR : '0;
            base_reg <= (ctrl.load_kind == KIND_QUERY) ? TOP_BASE : '0;
        end
        else if (ctrl.ops.ptr_op == PTR_INC)
        begin
            ptr_reg  <= ptr_reg + PTR_W'(1);
            base_reg <= base_reg + BS_P;
        end
        else if (ctrl.ops.ptr_op == PTR_DEC)
        begin
            ptr_reg  <= ptr_reg - PTR_W'(1);
            base_reg <= base_reg - BS_P;
        end

        if (ctrl.ops.elem_wr)
        begin
            delta_reg <= SUM_W'(val_reg) - elem_val;
        end

        if (ctrl.ops.latch_blk)
        begin
            fblk_reg  <= rd_blk_reg;
            fbase_reg <= rd_base_reg;
        end

        // accumulator starts from the sum of the following block
        if (ctrl.ops.acc_op == ACC_LOAD)
        begin
            acc_reg  <= (fblk_reg == LAST_BLK) ? '0 : sum_rd_reg;
            epos_reg <= fbase_reg + BS_P - POS_W'(1);
            k_reg    <= K_TOP;
        end
        else
        begin
            if (ctrl.ops.acc_op == ACC_ADD)
            begin
                acc_reg <= acc_sum;
            end
            if (ctrl.ops.elem_rd == ERD_POS)
            begin
                epos_reg <= epos_reg - POS_W'(1);
                k_reg    <= k_reg - KW'(1);
                rd_k_reg <= k_reg;
            end
        end
    end

    // Clearing pass counter
    assign clr_next = ctrl.ops.clr ? clr_reg + CW'(1) : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

`ifndef NO_ASSERTIONS
    // sum memory is never read and written at the same entry in one cycle
    a_sum_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.ops.sum_wr && (ctrl.ops.sum_rd != SRD_NONE)) |-> (sa != rd_blk_reg))
        else $error("sum memory read and write collide");

    // an element is stored only inside the array
    a_elem_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ops.elem_wr |-> (idx_reg < LIMIT_P))
        else $error("element write outside the array");

    // clearing never runs past its end
    a_clr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ops.clr |-> (clr_reg < CLR_C))
        else $error("clearing pass overran");
`endif

endmodule

FILE: hdl/ssm_seq.sv
module ssm_seq
    import ssm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_kind,
    output logic      cmd_ready,
    output logic      rsp_valid,
    output logic      rsp_found,
    input  logic      rsp_ready,
    input  dp_flags_t flags,
    output dp_ctrl_t  ctrl
);

    upc_t   upc_reg;
    upc_t   upc_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   found_reg;
    logic   found_next;
    ucode_t cw;
    logic   cond_hit;
    logic   slot_free;

    assign cw        = ucode_rom(upc_reg);
    assign slot_free = !out_valid_reg || rsp_ready;

    // Condition select
    always_comb
    begin
        case (cw.cond)
            C_CLR_END:  cond_hit = flags.clr_end;
            C_WBAD:     cond_hit = flags.wbad;
            C_BASE_GT:  cond_hit = flags.base_gt;
            C_SCAN_END: cond_hit = flags.scan_end;
            C_LT:       cond_hit = flags.sum_lt;
            C_SUMEQ:    cond_hit = flags.sum_eq;
            C_EEND:     cond_hit = flags.elem_end;
            C_EHIT:     cond_hit = flags.elem_hit;
            default:    cond_hit = 1'b0;
        endcase
    end

    // Next address, datapath strobes and result register
    always_comb
    begin
        upc_next       = upc_reg + UPC_W'(1);
        ctrl.load      = 1'b0;
        ctrl.load_kind = cmd_kind;
        ctrl.ops       = cw.ops;
        cmd_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        found_next     = found_reg;
        case (cw.seq)
            SEQ_NEXT:
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
            SEQ_BR:
            begin
                upc_next = cond_hit ? cw.jaddr : upc_reg + UPC_W'(1);
            end
            SEQ_LOOP:
            begin
                if (cond_hit)
                begin
                    upc_next = cw.jaddr;
                    ctrl.ops = OPS_NONE;
                end
                else
                begin
                    upc_next = upc_reg;
                end
            end
            SEQ_FETCH:
            begin
                cmd_ready = 1'b1;
                ctrl.load = cmd_valid;
                if (cmd_valid)
                begin
                    upc_next = (cmd_kind == KIND_QUERY) ? A_Q0 : A_W0;
                end
                else
                begin
                    upc_next = upc_reg;
                end
            end
            SEQ_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = cw.emit_val;
                    upc_next       = A_FETCH;
                end
                else
                begin
                    upc_next = upc_reg;
                end
            end
            SEQ_END:
            begin
                upc_next = A_FETCH;
            end
            default:
            begin
                upc_next = A_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_found = found_reg;

`ifndef NO_ASSERTIONS
    // an accepted item starts the write or the query routine
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> ((upc_reg == A_W0) || (upc_reg == A_Q0)))
        else $error("bad dispatch after accept");

    // the program counter stays inside the control store
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= A_LAST)
        else $error("program counter out of range");

    // a result appears only from one of the answer words
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(upc_reg) == A_YES || $past(upc_reg) == A_NO))
        else $error("result raised outside an answer step");
`endif

endmodule

FILE: hdl/suffix_sum_match_search_core.sv
// Suffix sum match search. Holds DEPTH 32-bit elements (zero after reset)
// in blocks of BLOCK_SIZE, with a 48-bit suffix sum per block. A write item
// (kind 0) replaces one element and returns nothing; an index at or beyond
// DEPTH or NUM_BLOCKS*BLOCK_SIZE is ignored. A query item (kind 1) returns
// one item, found, telling whether some suffix of the array sums exactly to
// target. Control is a small microprogram; each step reads at most one block
// sum and one element, so the block memory and element memory ports set the
// timing: a write updates the block sums from block 0 up to the block of the
// index; a query scans the block sums down from the last block and, if the
// found block's sum exceeds the target, walks its elements from its end. One
// item is worked on at a time; a finished result waits in an output register
// while the next item is accepted. After reset a clearing pass runs before the
// first item is taken.
module suffix_sum_match_search_core
    import ssm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    ssm_cmd_if.sink  cmd,
    ssm_rsp_if.source rsp
);

    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    // Microcode sequencer
    ssm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_kind  (cmd.kind),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_found (rsp.found),
        .rsp_ready (rsp.ready),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    // Memories and arithmetic
    ssm_dp #(
        .DEPTH      (DEPTH),
        .BLOCK_SIZE (BLOCK_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .index  (cmd.index),
        .value  (cmd.value),
        .target (cmd.target),
        .flags  (flags)
    );

endmodule

FILE: bench/testbench.sv
module testbench;
    import ssm_pkg::*;

    localparam int DEP            = DEPTH_DEF;
    localparam int BLK            = BLOCK_SIZE_DEF;
    localparam int NBLK           = NUM_BLOCKS_DEF;
    localparam int RAND_PER_PHASE = 135;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 100;

    // One row of the directed part; known marks a hand-typed answer
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic [SUM_W-1:0] target;
        logic             known;
        logic             found;
    } dir_row_t;

    dir_row_t dir_tab [23] = '{
        // empty array: the last block sums to zero, nothing reaches one
        '{KIND_QUERY, 10'd0, 32'd0, 48'd0, 1'b1, 1'b1},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd1, 1'b1, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0},
        // full element at the very end
        '{KIND_WRITE, 10'd1023, 32'hFFFF_FFFF, 48'd0, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'h0000_FFFF_FFFF, 1'b1, 1'b1},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd0, 1'b0, 1'b0},
        // full element at the start: block 0 sum is the whole array
        '{KIND_WRITE, 10'd0, 32'hFFFF_FFFF, 48'd0, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'h0001_FFFF_FFFE, 1'b1, 1'b1},
        '{KIND_QUERY, 10'd0, 32'd0, 48'h0001_FFFF_FFFF, 1'b1, 1'b0},
        // shrinking writes take the change off the block sums
        '{KIND_WRITE, 10'd0, 32'd0, 48'd0, 1'b0, 1'b0},
        '{KIND_WRITE, 10'd1023, 32'd0, 48'd0, 1'b0, 1'b0},
        // scan inside one block
        '{KIND_WRITE, 10'd515, 32'd7, 48'd0, 1'b0, 1'b0},
        '{KIND_WRITE, 10'd512, 32'd5, 48'd0, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd7, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd12, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd5, 1'b0, 1'b0},
        // alternating bit patterns on index and value
        '{KIND_WRITE, 10'h2AA, 32'hAAAA_AAAA, 48'd0, 1'b0, 1'b0},
        '{KIND_WRITE, 10'h155, 32'h5555_5555, 48'd0, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'h0000_AAAA_AAB6, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'h5555_5555_5555, 1'b0, 1'b0},
        // zero target met by a zero element scanned from the end
        '{KIND_WRITE, 10'd1000, 32'd3, 48'd0, 1'b0, 1'b0},
        '{KIND_QUERY, 10'd0, 32'd0, 48'd0, 1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;

    ssm_cmd_if cmd_ch ();
    ssm_rsp_if rsp_ch ();

    suffix_sum_match_search_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the array and of the per-block suffix sums
    logic [VAL_W-1:0] shadow_elems  [DEP];
    logic [SUM_W-1:0] shadow_suffix [NBLK];
    logic             found_q [$];

    int   errors;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_left;
    logic hold_start;
    logic hold_done = 1'b0;
    int   quiet;
    logic want;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Replace one element and carry the change into its block and all earlier ones
    function automatic void store_element(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        logic [SUM_W-1:0] delta;
        int b;
        delta = SUM_W'(val) - SUM_W'(shadow_elems[idx]);
        for (b = 0; b <= int'(idx) / BLK; b++)
            shadow_suffix[b] = shadow_suffix[b] + delta;
        shadow_elems[idx] = val;
    endfunction

    // Last block reaching the target, then backward scan of that block
    function automatic logic suffix_match(logic [SUM_W-1:0] target);
        int blk;
        int k;
        logic [SUM_W-1:0] acc;
        for (blk = NBLK - 1; blk >= 0; blk--)
            if (shadow_suffix[blk] >= target)
                break;
        if (blk < 0)
            return 1'b0;
        if (shadow_suffix[blk] == target)
            return 1'b1;
        acc = (blk < NBLK - 1) ? shadow_suffix[blk + 1] : '0;
        for (k = BLK - 1; k >= 0; k--)
        begin
            acc = acc + SUM_W'(shadow_elems[blk * BLK + k]);
            if (acc == target)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // True sum from a position to the end of the array
    function automatic logic [SUM_W-1:0] tail_sum(int start);
        logic [SUM_W-1:0] s;
        int i;
        s = '0;
        for (i = start; i < DEP; i++)
            s = s + SUM_W'(shadow_elems[i]);
        return s;
    endfunction

    // Offer one item, wait for acceptance, then update the shadow state
    task automatic send_item(logic kind, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic [SUM_W-1:0] tgt, logic known, logic exp_found);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.kind   <= kind;
        cmd_ch.index  <= idx;
        cmd_ch.value  <= val;
        cmd_ch.target <= tgt;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        if (kind == KIND_WRITE)
            store_element(idx, val);
        else
            found_q.insert(found_q.size(), known ? exp_found : suffix_match(tgt));
    endtask

    // Sender stops until every outstanding answer is back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (found_q.size() != 0);
    endtask

    // Receiver: random back-pressure, plus one long hold when asked
    always @(posedge clk)
    begin
        if (hold_start === 1'b1 && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (rst_n !== 1'b1)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Answer checker
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (found_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual found=%b",
                         $time, rsp_ch.found);
                errors++;
            end
            else
            begin
                want = found_q.pop_front();
                if (rsp_ch.found !== want)
                begin
                    $display("%0t: found mismatch, expected %b, actual %b",
                             $time, want, rsp_ch.found);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet);
            $display("suffix_sum_match_search_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int n;
        int i;
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [SUM_W-1:0] tgt;

        tx_idle_pct = 30;
        rx_idle_pct = 75;
        hold_start  = 1'b0;
        for (i = 0; i < DEP; i++)
            shadow_elems[i] = '0;
        for (i = 0; i < NBLK; i++)
            shadow_suffix[i] = '0;

        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.kind   <= KIND_WRITE;
        cmd_ch.index  <= '0;
        cmd_ch.value  <= '0;
        cmd_ch.target <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        for (i = 0; i < $size(dir_tab); i++)
            send_item(dir_tab[i].kind, dir_tab[i].index, dir_tab[i].value,
                      dir_tab[i].target, dir_tab[i].known, dir_tab[i].found);
        drain_results();

        // Random part in three back-pressure regimes
        for (ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 75 : 0;
            rx_idle_pct <= (ph == 0) ? 75 : (ph == 1) ? 30 : 0;
            for (n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (ph == 0 && n == 40)
                    hold_start <= 1'b1;
                kind = $urandom_range(1) ? KIND_QUERY : KIND_WRITE;
                // writes favour the tail so the scanned blocks are populated
                idx = $urandom_range(1) ? IDX_W'($urandom_range(DEP - 1))
                                        : IDX_W'($urandom_range(DEP - 1, DEP - 4 * BLK));
                case ($urandom_range(2))
                    0: val = '0;
                    1: val = VAL_W'($urandom_range(255));
                    default: val = VAL_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3: tgt = tail_sum($urandom_range(DEP - 1));
                    4: tgt = tail_sum($urandom_range(DEP - 1)) + 1'b1;
                    5: tgt = tail_sum($urandom_range(DEP - 1)) - 1'b1;
                    6: tgt = '0;
                    7: tgt = shadow_suffix[$urandom_range(NBLK - 1)];
                    default: tgt = SUM_W'({$urandom, $urandom});
                endcase
                send_item(kind, idx, val, tgt, 1'b0, 1'b0);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("suffix_sum_match_search_core verification clean");
        else
            $display("suffix_sum_match_search_core verification failed");
        $finish;
    end

endmodule
